[design/pwfr_pkg.sv]
// shared types, constants and register map of the pulse width frame receiver
package pwfr_pkg;

   // counter widths
   localparam int PULSE_COUNT_BITS = 16;
   localparam int IDLE_COUNT_BITS  = 20;
   localparam int CMP_BITS         = 32;

   // register widths
   localparam int PULSE_CFG_BITS = 16;
   localparam int IDLE_CFG_BITS  = 20;

   // token queue, depth a power of two
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // configuration port
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   // register reset values
   localparam logic [PULSE_CFG_BITS-1:0] SYNC_MIN_RESET = 16'd2000;
   localparam logic [PULSE_CFG_BITS-1:0] SYNC_MAX_RESET = 16'd2900;
   localparam logic [PULSE_CFG_BITS-1:0] ONE_MIN_RESET  = 16'd950;
   localparam logic [PULSE_CFG_BITS-1:0] ONE_MAX_RESET  = 16'd1400;
   localparam logic [PULSE_CFG_BITS-1:0] ZERO_MIN_RESET = 16'd450;
   localparam logic [PULSE_CFG_BITS-1:0] ZERO_MAX_RESET = 16'd750;
   localparam logic [IDLE_CFG_BITS-1:0]  END_IDLE_RESET = 20'd200000;

   localparam logic [7:0] BYTE_INDEX_MAX = 8'd255;
   localparam logic [7:0] BIT_MSB_MASK   = 8'h80;
   localparam logic [2:0] LAST_BIT       = 3'd7;

   typedef enum logic [2:0] {
      CSR_SYNC_MIN = 3'd0,
      CSR_SYNC_MAX = 3'd1,
      CSR_ONE_MIN  = 3'd2,
      CSR_ONE_MAX  = 3'd3,
      CSR_ZERO_MIN = 3'd4,
      CSR_ZERO_MAX = 3'd5,
      CSR_END_IDLE = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      EV_DATA = 2'd0,
      EV_SYNC = 2'd1,
      EV_END  = 2'd2
   } event_kind_type;

   typedef enum logic [1:0] {
      PC_NONE = 2'd0,
      PC_SYNC = 2'd1,
      PC_ONE  = 2'd2,
      PC_ZERO = 2'd3
   } pulse_class_type;

   typedef struct packed {
      logic [PULSE_CFG_BITS-1:0] sync_min;
      logic [PULSE_CFG_BITS-1:0] sync_max;
      logic [PULSE_CFG_BITS-1:0] one_min;
      logic [PULSE_CFG_BITS-1:0] one_max;
      logic [PULSE_CFG_BITS-1:0] zero_min;
      logic [PULSE_CFG_BITS-1:0] zero_max;
      logic [IDLE_CFG_BITS-1:0]  end_idle;
   } cfg_type;

   // one classified line event for the frame engine
   typedef struct packed {
      pulse_class_type pulse;
      logic            idle;
   } token_type;

   typedef struct packed {
      logic      valid;
      token_type token;
   } q_push_type;

   typedef struct packed {
      logic      valid;
      token_type token;
   } q_head_type;

endpackage

[design/pwfr_req_if.sv]
// line sample channel
interface pwfr_req_if;
   logic valid;
   logic ready;
   logic line_level;

   modport source (output valid, output line_level, input ready);
   modport sink   (input valid, input line_level, output ready);
endinterface

[design/pwfr_rsp_if.sv]
// frame event channel
interface pwfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_kind;
   logic [7:0] data_byte;
   logic [7:0] byte_index;

   modport source (output valid, output event_kind, output data_byte, output byte_index,
                   input ready);
   modport sink   (input valid, input event_kind, input data_byte, input byte_index,
                   output ready);
endinterface

[design/pwfr_front.sv]
// pulse measurement and window classification
module pwfr_front (
   input  logic                 clock,
   input  logic                 reset,
   pwfr_req_if.sink             req,
   input  pwfr_pkg::cfg_type    cfg,
   input  logic                 q_full,
   output pwfr_pkg::q_push_type push
);

   localparam logic [pwfr_pkg::PULSE_COUNT_BITS-1:0] PULSE_MAX = '1;
   localparam logic [pwfr_pkg::IDLE_COUNT_BITS-1:0]  IDLE_MAX  = '1;

   logic                                  prev_level_ff, prev_level_in;
   logic [pwfr_pkg::PULSE_COUNT_BITS-1:0] low_count_ff, low_count_in;
   logic [pwfr_pkg::IDLE_COUNT_BITS-1:0]  high_count_ff, high_count_in;
   logic                                  idle_sent_ff, idle_sent_in;

   logic                                  accept;
   logic                                  idle_reached;
   logic [pwfr_pkg::CMP_BITS-1:0]         len;
   pwfr_pkg::pulse_class_type             pulse_class;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;

   // windows with exclusive bounds, sync before one before zero
   assign len = pwfr_pkg::CMP_BITS'(low_count_ff);

   always_comb begin
      priority if (len > pwfr_pkg::CMP_BITS'(cfg.sync_min) &&
                   len < pwfr_pkg::CMP_BITS'(cfg.sync_max)) begin
         pulse_class = pwfr_pkg::PC_SYNC;
      end else if (len > pwfr_pkg::CMP_BITS'(cfg.one_min) &&
                   len < pwfr_pkg::CMP_BITS'(cfg.one_max)) begin
         pulse_class = pwfr_pkg::PC_ONE;
      end else if (len > pwfr_pkg::CMP_BITS'(cfg.zero_min) &&
                   len < pwfr_pkg::CMP_BITS'(cfg.zero_max)) begin
         pulse_class = pwfr_pkg::PC_ZERO;
      end else begin
         pulse_class = pwfr_pkg::PC_NONE;
      end
   end

   always_comb begin
      prev_level_in = prev_level_ff;
      low_count_in  = low_count_ff;
      high_count_in = high_count_ff;
      idle_sent_in  = idle_sent_ff;
      idle_reached  = 1'b0;
      push          = '0;
      if (accept) begin
         if (!req.line_level) begin
            if (prev_level_ff) begin
               low_count_in = {{(pwfr_pkg::PULSE_COUNT_BITS-1){1'b0}}, 1'b1};
            end else if (low_count_ff != PULSE_MAX) begin
               low_count_in = low_count_ff + 1'b1;
            end
            high_count_in = '0;
            idle_sent_in  = 1'b0;
            prev_level_in = 1'b0;
         end else begin
            if (high_count_ff != IDLE_MAX) begin
               high_count_in = high_count_ff + 1'b1;
            end
            idle_reached = pwfr_pkg::CMP_BITS'(high_count_in) >=
                           pwfr_pkg::CMP_BITS'(cfg.end_idle);
            prev_level_in = 1'b1;
            if (!prev_level_ff) begin
               // rising edge: pulse class plus idle test on the same tick
               push.valid       = (pulse_class != pwfr_pkg::PC_NONE) || idle_reached;
               push.token.pulse = pulse_class;
               push.token.idle  = idle_reached;
               idle_sent_in     = 1'b0;
            end else if (idle_reached && !idle_sent_ff) begin
               // later high ticks repeat the same test, so one token is enough
               push.valid       = 1'b1;
               push.token.pulse = pwfr_pkg::PC_NONE;
               push.token.idle  = 1'b1;
               idle_sent_in     = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff <= 1'b1;
         low_count_ff  <= '0;
         high_count_ff <= '0;
         idle_sent_ff  <= 1'b0;
      end else begin
         prev_level_ff <= prev_level_in;
         low_count_ff  <= low_count_in;
         high_count_ff <= high_count_in;
         idle_sent_ff  <= idle_sent_in;
      end
   end

endmodule

[design/pwfr_queue.sv]
// token queue between classifier and frame engine
module pwfr_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  pwfr_pkg::q_push_type push,
   input  logic                 pop,
   output logic                 full,
   output pwfr_pkg::q_head_type head
);

   pwfr_pkg::token_type                 entry_ff [pwfr_pkg::QUEUE_DEPTH];
   logic [pwfr_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pwfr_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pwfr_pkg::QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                                do_pop;

   assign full       = count_ff == pwfr_pkg::QUEUE_CNT_BITS'(pwfr_pkg::QUEUE_DEPTH);
   assign head.valid = count_ff != '0;
   assign head.token = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({push.valid, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.token;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[design/pwfr_back.sv]
// frame engine: byte assembly, frame state and result register
module pwfr_back (
   input  logic                 clock,
   input  logic                 reset,
   input  pwfr_pkg::q_head_type head,
   output logic                 pop,
   pwfr_rsp_if.source           rsp
);

   logic       in_frame_ff, in_frame_in;
   logic       has_data_ff, has_data_in;
   logic [2:0] bit_count_ff, bit_count_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] bytes_ff, bytes_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_kind_ff, rsp_kind_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic [7:0] rsp_index_ff, rsp_index_in;

   logic       emit;
   logic [7:0] shift_next;

   assign pop = head.valid && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      in_frame_in  = in_frame_ff;
      has_data_in  = has_data_ff;
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      bytes_in     = bytes_ff;
      emit         = 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_index_in = rsp_index_ff;
      shift_next   = shift_ff;
      if (head.token.pulse == pwfr_pkg::PC_ONE) begin
         shift_next = shift_ff | (pwfr_pkg::BIT_MSB_MASK >> bit_count_ff);
      end
      if (pop) begin
         unique case (head.token.pulse)
            pwfr_pkg::PC_SYNC: begin
               in_frame_in  = 1'b1;
               has_data_in  = 1'b0;
               bit_count_in = '0;
               shift_in     = '0;
               bytes_in     = '0;
               emit         = 1'b1;
               rsp_kind_in  = pwfr_pkg::EV_SYNC;
               rsp_data_in  = '0;
               rsp_index_in = '0;
            end
            pwfr_pkg::PC_ONE, pwfr_pkg::PC_ZERO: begin
               if (in_frame_ff) begin
                  if (bit_count_ff == pwfr_pkg::LAST_BIT) begin
                     emit         = 1'b1;
                     rsp_kind_in  = pwfr_pkg::EV_DATA;
                     rsp_data_in  = shift_next;
                     rsp_index_in = bytes_ff;
                     if (bytes_ff != pwfr_pkg::BYTE_INDEX_MAX) begin
                        bytes_in = bytes_ff + 1'b1;
                     end
                     has_data_in  = 1'b1;
                     bit_count_in = '0;
                     shift_in     = '0;
                  end else begin
                     shift_in     = shift_next;
                     bit_count_in = bit_count_ff + 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
         // frame end only on a tick that gave nothing else
         if (!emit && head.token.idle && in_frame_in && has_data_in) begin
            emit         = 1'b1;
            rsp_kind_in  = pwfr_pkg::EV_END;
            rsp_data_in  = '0;
            rsp_index_in = '0;
            in_frame_in  = 1'b0;
            has_data_in  = 1'b0;
            bit_count_in = '0;
            shift_in     = '0;
            bytes_in     = '0;
         end
      end
      rsp_valid_in = pop ? emit : (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff  <= 1'b0;
         has_data_ff  <= 1'b0;
         bit_count_ff <= '0;
         shift_ff     <= '0;
         bytes_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_frame_ff  <= in_frame_in;
         has_data_ff  <= has_data_in;
         bit_count_ff <= bit_count_in;
         shift_ff     <= shift_in;
         bytes_ff     <= bytes_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff  <= rsp_kind_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.event_kind = rsp_kind_ff;
   assign rsp.data_byte  = rsp_data_ff;
   assign rsp.byte_index = rsp_index_ff;

endmodule

[design/pulse_width_frame_receiver.sv]
// pulse width frame receiver: top level with register block
// The block takes one line sample per clock on req while req.ready is high;
// req.ready is high whenever the four-entry token queue has room,
// which is always unless rsp has been held off for several pulses in a row.
// Low pulses are timed in the front part and classified at the rising edge
// against the sync, one and zero windows (bounds exclusive); a sync gives a
// frame start item, every eighth bit a data byte item, and a long high idle in
// a frame that holds data gives a frame end item. A result reaches rsp through
// the token queue and then the result register. Registers on the csr port sit at
// byte address 4*index; the user is to write them only while the line is idle,
// which the block itself does not enforce.
module pulse_width_frame_receiver (
   input  logic                               clock,
   input  logic                               reset,
   pwfr_req_if.sink                           req,
   pwfr_rsp_if.source                         rsp,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [pwfr_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [pwfr_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [pwfr_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);

   // window and idle registers
   pwfr_pkg::cfg_type    cfg_ff, cfg_in;
   logic                 csr_write;
   logic [2:0]           csr_index;

   // front to queue to back
   pwfr_pkg::q_push_type push;
   pwfr_pkg::q_head_type head;
   logic                 q_full;
   logic                 pop;

   // apb: no wait states, write lands on the access phase
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            pwfr_pkg::CSR_SYNC_MIN: cfg_in.sync_min = csr_pwdata[15:0];
            pwfr_pkg::CSR_SYNC_MAX: cfg_in.sync_max = csr_pwdata[15:0];
            pwfr_pkg::CSR_ONE_MIN:  cfg_in.one_min  = csr_pwdata[15:0];
            pwfr_pkg::CSR_ONE_MAX:  cfg_in.one_max  = csr_pwdata[15:0];
            pwfr_pkg::CSR_ZERO_MIN: cfg_in.zero_min = csr_pwdata[15:0];
            pwfr_pkg::CSR_ZERO_MAX: cfg_in.zero_max = csr_pwdata[15:0];
            pwfr_pkg::CSR_END_IDLE: cfg_in.end_idle = csr_pwdata[19:0];
            default: begin
               // address beyond the map: write dropped
            end
         endcase
      end
   end

   // read back, zero beyond the map
   always_comb begin
      unique case (csr_index)
         pwfr_pkg::CSR_SYNC_MIN: csr_prdata = pwfr_pkg::CSR_DATA_BITS'(cfg_ff.sync_min);
         pwfr_pkg::CSR_SYNC_MAX: csr_prdata = pwfr_pkg::CSR_DATA_BITS'(cfg_ff.sync_max);
         pwfr_pkg::CSR_ONE_MIN:  csr_prdata = pwfr_pkg::CSR_DATA_BITS'(cfg_ff.one_min);
         pwfr_pkg::CSR_ONE_MAX:  csr_prdata = pwfr_pkg::CSR_DATA_BITS'(cfg_ff.one_max);
         pwfr_pkg::CSR_ZERO_MIN: csr_prdata = pwfr_pkg::CSR_DATA_BITS'(cfg_ff.zero_min);
         pwfr_pkg::CSR_ZERO_MAX: csr_prdata = pwfr_pkg::CSR_DATA_BITS'(cfg_ff.zero_max);
         pwfr_pkg::CSR_END_IDLE: csr_prdata = pwfr_pkg::CSR_DATA_BITS'(cfg_ff.end_idle);
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_min <= pwfr_pkg::SYNC_MIN_RESET;
         cfg_ff.sync_max <= pwfr_pkg::SYNC_MAX_RESET;
         cfg_ff.one_min  <= pwfr_pkg::ONE_MIN_RESET;
         cfg_ff.one_max  <= pwfr_pkg::ONE_MAX_RESET;
         cfg_ff.zero_min <= pwfr_pkg::ZERO_MIN_RESET;
         cfg_ff.zero_max <= pwfr_pkg::ZERO_MAX_RESET;
         cfg_ff.end_idle <= pwfr_pkg::END_IDLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: pulse timing and classification, one token per useful tick
   pwfr_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .cfg    (cfg_ff),
      .q_full (q_full),
      .push   (push)
   );

   // queue lets the sample side run on while rsp is stalled
   pwfr_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (q_full),
      .head  (head)
   );

   // back: frame state and the result register
   pwfr_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp)
   );

endmodule

[design/pwfr_checker.sv]
// port level checks for the pulse width frame receiver, with bind
module pwfr_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [1:0]                         rsp_event_kind,
   input logic [7:0]                         rsp_data_byte,
   input logic [7:0]                         rsp_byte_index,
   input logic                               csr_psel,
   input logic                               csr_penable,
   input logic                               csr_pwrite,
   input logic [pwfr_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input logic [pwfr_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   input logic [pwfr_pkg::CSR_DATA_BITS-1:0] csr_prdata
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_kind) &&
         $stable(rsp_data_byte) && $stable(rsp_byte_index))
      else $error("stalled result changed");

   // frame start and frame end carry no byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind != pwfr_pkg::EV_DATA |->
         rsp_data_byte == 8'd0 && rsp_byte_index == 8'd0)
      else $error("non data item with payload");

   // nothing left over from before reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a register reads back what was written, cut to its width
   assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_paddr[4:2] <= pwfr_pkg::CSR_END_IDLE) ##1
         (csr_psel && !csr_pwrite && csr_paddr[4:2] == $past(csr_paddr[4:2])) |->
         csr_prdata == (($past(csr_paddr[4:2]) == pwfr_pkg::CSR_END_IDLE) ?
            {12'd0, $past(csr_pwdata[19:0])} : {16'd0, $past(csr_pwdata[15:0])}))
      else $error("register read back mismatch");

endmodule

bind pulse_width_frame_receiver pwfr_checker u_pwfr_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_event_kind (rsp.event_kind),
   .rsp_data_byte  (rsp.data_byte),
   .rsp_byte_index (rsp.byte_index),
   .csr_psel       (csr_psel),
   .csr_penable    (csr_penable),
   .csr_pwrite     (csr_pwrite),
   .csr_paddr      (csr_paddr),
   .csr_pwdata     (csr_pwdata),
   .csr_prdata     (csr_prdata)
);

[tb/frame_event_checker.sv]
// frame event checker: predicts frame events from observed line samples and register writes
`timescale 1ns / 100ps

module frame_event_checker
   import pwfr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     sample_valid,
   input  logic                     sample_ready,
   input  logic                     sample_level,
   input  logic                     event_valid,
   input  logic                     event_ready,
   input  logic [1:0]               event_kind,
   input  logic [7:0]               event_data,
   input  logic [7:0]               event_index,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic                     csr_pready,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output int                       mismatch_count,
   output int                       events_pending,
   output int                       bytes_seen,
   output int                       starts_seen,
   output int                       ends_seen
);

   localparam logic [2:0] FINAL_BIT_POS = 3'd7;
   localparam logic [7:0] INDEX_CEILING = 8'd255;
   localparam logic [7:0] FIRST_BIT     = 8'h80;

   typedef struct packed {
      event_kind_type kind;
      logic [7:0]     data;
      logic [7:0]     index;
   } frame_event_type;

   frame_event_type expected_events[$];

   cfg_type                      windows;
   logic                         prev_level;
   logic [PULSE_COUNT_BITS-1:0]  low_len;
   logic [IDLE_COUNT_BITS-1:0]   high_len;
   logic [2:0]                   bit_pos;
   logic [7:0]                   shifter;
   logic                         in_frame;
   logic                         has_data;
   logic [7:0]                   byte_pos;

   // bounds are exclusive on both sides
   function automatic bit fits(input logic [PULSE_COUNT_BITS-1:0] len,
                               input logic [PULSE_CFG_BITS-1:0] lo,
                               input logic [PULSE_CFG_BITS-1:0] hi);
      return (len > lo) && (len < hi);
   endfunction

   task automatic restart_frame();
      bit_pos  = '0;
      shifter  = '0;
      has_data = 1'b0;
      byte_pos = '0;
   endtask

   task automatic note_event(input event_kind_type kind, input logic [7:0] data,
                             input logic [7:0] index);
      frame_event_type ev;
      ev.kind  = kind;
      ev.data  = data;
      ev.index = index;
      expected_events.push_back(ev);
   endtask

   task automatic decode_sample(input logic level);
      logic [PULSE_COUNT_BITS-1:0] len;
      bit                          emitted;
      bit                          is_one;
      bit                          is_zero;
      emitted = 1'b0;
      if (!level) begin
         if (prev_level) begin
            low_len = 1;
         end else if (low_len != '1) begin
            low_len = low_len + 1'b1;
         end
         high_len   = '0;
         prev_level = 1'b0;
      end else begin
         if (high_len != '1) begin
            high_len = high_len + 1'b1;
         end
         if (!prev_level) begin
            len = low_len;
            if (fits(len, windows.sync_min, windows.sync_max)) begin
               in_frame = 1'b1;
               restart_frame();
               note_event(EV_SYNC, 8'h00, 8'h00);
               emitted = 1'b1;
            end else if (in_frame) begin
               is_one  = fits(len, windows.one_min, windows.one_max);
               is_zero = fits(len, windows.zero_min, windows.zero_max);
               if (is_one || is_zero) begin
                  if (is_one) begin
                     shifter = shifter | (FIRST_BIT >> bit_pos);
                  end
                  if (bit_pos == FINAL_BIT_POS) begin
                     note_event(EV_DATA, shifter, byte_pos);
                     emitted = 1'b1;
                     if (byte_pos != INDEX_CEILING) begin
                        byte_pos = byte_pos + 1'b1;
                     end
                     has_data = 1'b1;
                     bit_pos  = '0;
                     shifter  = '0;
                  end else begin
                     bit_pos = bit_pos + 1'b1;
                  end
               end
            end
         end
         prev_level = 1'b1;
         if (!emitted && in_frame && has_data && (high_len >= windows.end_idle)) begin
            note_event(EV_END, 8'h00, 8'h00);
            in_frame = 1'b0;
            restart_frame();
         end
      end
   endtask

   always @(posedge clock) begin
      frame_event_type want;
      if (reset) begin
         expected_events.delete();
         windows = cfg_type'{sync_min: 16'd2000, sync_max: 16'd2900,
                             one_min: 16'd950, one_max: 16'd1400,
                             zero_min: 16'd450, zero_max: 16'd750,
                             end_idle: 20'd200000};
         prev_level     = 1'b1;
         low_len        = '0;
         high_len       = '0;
         in_frame       = 1'b0;
         restart_frame();
         mismatch_count = 0;
         bytes_seen     = 0;
         starts_seen    = 0;
         ends_seen      = 0;
      end else begin
         if (event_valid && event_ready) begin
            if (expected_events.size() == 0) begin
               mismatch_count++;
               $display("%0t: expected no frame event, got kind %0d data %02h index %0d",
                        $time, event_kind, event_data, event_index);
            end else begin
               want = expected_events.pop_front();
               if (want.kind !== event_kind || want.data !== event_data ||
                   want.index !== event_index) begin
                  mismatch_count++;
                  $display("%0t: expected kind %0d data %02h index %0d, got kind %0d data %02h index %0d",
                           $time, want.kind, want.data, want.index,
                           event_kind, event_data, event_index);
               end
               case (want.kind)
                  EV_DATA: bytes_seen++;
                  EV_SYNC: starts_seen++;
                  EV_END:  ends_seen++;
                  default: ;
               endcase
            end
         end
         if (sample_valid && sample_ready) begin
            decode_sample(sample_level);
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]))
               CSR_SYNC_MIN: windows.sync_min = csr_pwdata[PULSE_CFG_BITS-1:0];
               CSR_SYNC_MAX: windows.sync_max = csr_pwdata[PULSE_CFG_BITS-1:0];
               CSR_ONE_MIN:  windows.one_min  = csr_pwdata[PULSE_CFG_BITS-1:0];
               CSR_ONE_MAX:  windows.one_max  = csr_pwdata[PULSE_CFG_BITS-1:0];
               CSR_ZERO_MIN: windows.zero_min = csr_pwdata[PULSE_CFG_BITS-1:0];
               CSR_ZERO_MAX: windows.zero_max = csr_pwdata[PULSE_CFG_BITS-1:0];
               CSR_END_IDLE: windows.end_idle = csr_pwdata[IDLE_CFG_BITS-1:0];
               default: ;
            endcase
         end
      end
      events_pending = expected_events.size();
   end

endmodule

[tb/tb_top.sv]
// testbench top: line sample stimulus, register phases, result flow control and verdict
`timescale 1ns / 100ps

module tb_top;
   import pwfr_pkg::*;

   // watchdog, generous against the slowest legal run (gaps on every item plus stalls)
   localparam int CYCLE_LIMIT     = 100_000;
   // receiver hold-off long enough to fill the token queue and stall req
   localparam int HOLD_OFF_CYCLES = 400;
   // quiet cycles after the last expected event
   localparam int DRAIN_CYCLES    = 8;
   localparam int RANDOM_PHASES   = 6;
   localparam int PHASE_BUDGET    = 40;
   // syncs sent into the hold-off, more than the queue and result register hold
   localparam int PILE_UP_SYNCS   = 6;

   logic                     clock;
   logic                     reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   pwfr_req_if req_ch ();
   pwfr_rsp_if rsp_ch ();

   int      mismatch_count;
   int      events_pending;
   int      bytes_seen;
   int      starts_seen;
   int      ends_seen;
   int      samples_sent;
   int      settings_used;
   int      cycle_count;
   bit      calm;
   bit      hold_off_wanted;
   // window settings currently loaded, used only to shape pulse lengths
   cfg_type active;

   pulse_width_frame_receiver dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   frame_event_checker event_check (
      .clock          (clock),
      .reset          (reset),
      .sample_valid   (req_ch.valid),
      .sample_ready   (req_ch.ready),
      .sample_level   (req_ch.line_level),
      .event_valid    (rsp_ch.valid),
      .event_ready    (rsp_ch.ready),
      .event_kind     (rsp_ch.event_kind),
      .event_data     (rsp_ch.data_byte),
      .event_index    (rsp_ch.byte_index),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .mismatch_count (mismatch_count),
      .events_pending (events_pending),
      .bytes_seen     (bytes_seen),
      .starts_seen    (starts_seen),
      .ends_seen      (ends_seen)
   );

   // 4 ns clock
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d frame events still outstanding",
                  cycle_count, events_pending);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // result side: short random stalls, one long hold-off on request, none once calm
   initial begin
      int stall;
      rsp_ch.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (hold_off_wanted) begin
            hold_off_wanted = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            rsp_ch.ready <= 1'b1;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(1, 3);
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // one line sample item; entered and left at a falling edge
   task automatic send_sample(input logic level);
      int gap;
      // sender gap burst, valid dropped before the item
      if (!calm && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 3);
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.line_level <= level;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      samples_sent++;
      @(negedge clock);
   endtask

   // a low pulse of the given length followed by a high stretch
   task automatic pulse(input int low_ticks, input int high_ticks);
      repeat (low_ticks) send_sample(1'b0);
      repeat (high_ticks) send_sample(1'b1);
   endtask

   // drop valid, wait for every predicted event, then let the pipeline drain
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (events_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input csr_index_type index, input logic [CSR_DATA_BITS-1:0] value);
      // setup
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      // access
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // new window set, only once the block has gone quiet
   task automatic load_windows(input cfg_type c);
      settle();
      csr_write(CSR_SYNC_MIN, CSR_DATA_BITS'(c.sync_min));
      csr_write(CSR_SYNC_MAX, CSR_DATA_BITS'(c.sync_max));
      csr_write(CSR_ONE_MIN, CSR_DATA_BITS'(c.one_min));
      csr_write(CSR_ONE_MAX, CSR_DATA_BITS'(c.one_max));
      csr_write(CSR_ZERO_MIN, CSR_DATA_BITS'(c.zero_min));
      csr_write(CSR_ZERO_MAX, CSR_DATA_BITS'(c.zero_max));
      csr_write(CSR_END_IDLE, CSR_DATA_BITS'(c.end_idle));
      active = c;
      settings_used++;
   endtask

   // a length strictly inside the window, or short noise when the window is empty
   function automatic int pick_len(input logic [PULSE_CFG_BITS-1:0] lo,
                                   input logic [PULSE_CFG_BITS-1:0] hi);
      if (int'(hi) > int'(lo) + 1) begin
         return $urandom_range(int'(lo) + 1, int'(hi) - 1);
      end
      return $urandom_range(1, 20);
   endfunction

   task automatic random_bit();
      if ($urandom_range(0, 1) == 1) begin
         pulse(pick_len(active.one_min, active.one_max), $urandom_range(1, 3));
      end else begin
         pulse(pick_len(active.zero_min, active.zero_max), $urandom_range(1, 3));
      end
   endtask

   // mostly well-formed frames with random content, the rest loose bits, noise and broken frames
   task automatic random_frames(input int budget);
      int start_count;
      int pick;
      int n_bits;
      start_count = samples_sent;
      while (samples_sent - start_count < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            // sync, one to three bytes, sometimes a trailing partial byte, then idle
            pulse(pick_len(active.sync_min, active.sync_max), $urandom_range(1, 3));
            n_bits = 8 * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0) begin
               n_bits += $urandom_range(1, 7);
            end
            repeat (n_bits) random_bit();
            repeat (int'(active.end_idle) + $urandom_range(0, 2)) send_sample(1'b1);
         end else if (pick < 80) begin
            // loose bit, inside a frame or before any sync
            random_bit();
         end else if (pick < 92) begin
            // noise pulse of any short length
            pulse($urandom_range(1, 24), $urandom_range(1, 3));
         end else begin
            // broken frame: sync and a few bits, cut off by what follows
            pulse(pick_len(active.sync_min, active.sync_max), $urandom_range(1, 3));
            repeat ($urandom_range(1, 7)) random_bit();
         end
      end
   endtask

   initial begin
      cfg_type next_windows;
      int      p;

      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.line_level = 1'b1;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      calm              = 1'b0;
      hold_off_wanted   = 1'b0;
      samples_sent      = 0;
      settings_used     = 1;
      active = cfg_type'{sync_min: 16'd2000, sync_max: 16'd2900, one_min: 16'd950,
                         one_max: 16'd1400, zero_min: 16'd450, zero_max: 16'd750,
                         end_idle: 20'd200000};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset windows: a short pulse matches nothing
      pulse(1, 2);

      // narrow windows for the directed part
      load_windows(cfg_type'{sync_min: 16'd12, sync_max: 16'd20, one_min: 16'd6,
                             one_max: 16'd10, zero_min: 16'd2, zero_max: 16'd5,
                             end_idle: 20'd30});
      pulse(12, 2);              // on the sync bound, too long for a bit: ignored
      pulse(13, 2);              // sync just inside
      pulse(3, 2);               // zero, both bounds
      pulse(4, 2);
      pulse(7, 2);               // one, both bounds
      pulse(9, 2);
      pulse(2, 2);               // on window bounds: ignored, partial byte kept
      pulse(5, 2);
      pulse(6, 2);
      pulse(10, 2);
      pulse(3, 2);
      pulse(7, 2);
      pulse(3, 2);
      pulse(7, 2);               // eighth bit, first byte
      pulse(9, 2);
      pulse(9, 2);
      pulse(19, 2);              // sync inside a frame drops the partial byte
      repeat (8) pulse(7, 2);    // all ones
      repeat (8) pulse(3, 2);    // all zeros
      repeat (30) send_sample(1'b1);   // idle reaches the bound: frame end
      pulse(7, 2);               // bits before any sync: ignored
      pulse(3, 2);
      pulse(20, 2);              // on the upper sync bound: ignored
      pulse(16, 40);             // frame without data never ends by idle
      pulse(3, 40);

      // all windows overlap so sync wins; idle bound of zero ends a frame as soon as it holds data
      load_windows(cfg_type'{sync_min: 16'd5, sync_max: 16'd15, one_min: 16'd5,
                             one_max: 16'd15, zero_min: 16'd0, zero_max: 16'd15,
                             end_idle: 20'd0});
      send_sample(1'b1);
      pulse(6, 1);
      repeat (8) pulse($urandom_range(1, 5), 2);
      pulse(15, 2);
      pulse(5, 2);
      random_frames(PHASE_BUDGET);

      // one and zero overlap so one wins; smallest nonzero idle bound
      load_windows(cfg_type'{sync_min: 16'd10, sync_max: 16'd16, one_min: 16'd2,
                             one_max: 16'd7, zero_min: 16'd0, zero_max: 16'd7,
                             end_idle: 20'd1});
      pulse(11, 2);
      repeat (8) pulse($urandom_range(1, 6), 2);
      pulse(16, 2);
      random_frames(PHASE_BUDGET);

      // sync from a zero floor, one window turned off by inverted extremes
      load_windows(cfg_type'{sync_min: 16'd0, sync_max: 16'd4, one_min: 16'd65535,
                             one_max: 16'd0, zero_min: 16'd3, zero_max: 16'd9,
                             end_idle: 20'd25});
      pulse(1, 2);
      pulse(3, 2);
      repeat (8) pulse($urandom_range(4, 8), 2);
      pulse(9, 2);
      repeat (25) send_sample(1'b1);
      random_frames(PHASE_BUDGET);

      // random window sets; the second one gets the long hold-off, the last runs calm
      for (p = 0; p < RANDOM_PHASES; p++) begin
         next_windows.zero_min = 16'($urandom_range(0, 3));
         next_windows.zero_max = next_windows.zero_min + 16'($urandom_range(2, 5));
         next_windows.one_min  = 16'($urandom_range(0, 8));
         next_windows.one_max  = next_windows.one_min + 16'($urandom_range(2, 6));
         next_windows.sync_min = 16'($urandom_range(4, 14));
         next_windows.sync_max = next_windows.sync_min + 16'($urandom_range(2, 8));
         next_windows.end_idle = 20'($urandom_range(1, 40));
         load_windows(next_windows);
         if (p == 1) begin
            hold_off_wanted = 1'b1;
            // every sync gives an item, so they pile up behind the held result
            repeat (PILE_UP_SYNCS) pulse(pick_len(active.sync_min, active.sync_max), 1);
         end
         if (p == RANDOM_PHASES - 1) begin
            calm = 1'b1;
         end
         random_frames(PHASE_BUDGET);
      end

      settle();

      $display("covered %0d line samples under %0d window settings, incl. overlapping",
               samples_sent, settings_used);
      $display("and empty windows, zero idle bound and a receiver hold-off");
      $display("checked %0d bytes, %0d starts, %0d ends", bytes_seen, starts_seen, ends_seen);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
